@@ rtl/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// spd_pkg
// shared constants, opcodes and beat types of the shortest path engine
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned NODES_DEF       = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned DIST_BITS       = 20;
  localparam int unsigned MAX_PATH        = 16;
  localparam int unsigned NODE_FIELD_W    = 4;
  localparam int unsigned WEIGHT_FIELD_W  = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [NODE_FIELD_W-1:0]   source_node;
    logic [NODE_FIELD_W-1:0]   target_node;
    logic [WEIGHT_FIELD_W-1:0] edge_weight;
    logic                      edge_present;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] path_node;
    logic                    found;
    logic                    last;
  } out_beat_t;

endpackage

@@ rtl/spd_if.sv @@
// ----------------------------------------------------------------------------
// spd_if
// valid/ready channels for request beats and path beats
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic               valid;
  logic               ready;
  spd_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spd_out_if;
  logic               valid;
  logic               ready;
  spd_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/shortest_path_dijkstra.sv @@
// ----------------------------------------------------------------------------
// shortest_path_dijkstra
// single-pair shortest path search over a stored directed weighted graph
// ----------------------------------------------------------------------------
//  channel  dir  beat           meaning
//  in_i     in   in_beat_t      edge write (opcode 0) or path query (opcode 1)
//  out_o    out  out_beat_t     path nodes, start first, or one not-found beat
//
//  an edge write goes straight to the edge memory; a query takes one node
//  memory sweep to clear, then per finished node one select sweep and, unless
//  that node is the goal, one relax sweep, then walks the predecessors back
//  from the goal and plays the path back one beat at a time
//  after reset all NODES*NODES edge entries are swept clear, ready low
//  the block takes one item at a time; ready stays low until the last beat
//  of a query is taken, and output stalls simply hold the beat
// ----------------------------------------------------------------------------
module shortest_path_dijkstra #(
  parameter int unsigned NODES       = spd_pkg::NODES_DEF,
  parameter int unsigned WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spd_in_if.sink    in_i,
  spd_out_if.source out_o
);
  import spd_pkg::*;

  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned EAW = $clog2(NODES * NODES);
  localparam int unsigned SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam int unsigned PLW = $clog2(MAX_PATH + 1);
  localparam int unsigned PIW = $clog2(MAX_PATH);
  localparam logic [NW-1:0]        LAST_NODE  = NW'(NODES - 1);
  localparam logic [DIST_BITS-1:0] DIST_MAX   = '1;
  localparam logic [SW-1:0]        DIST_MAX_W = SW'(DIST_MAX);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_RLX   = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_WALKW = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  // per-node search state, one memory word per node
  typedef struct packed {
    logic                 reached;
    logic                 finished;
    logic [DIST_BITS-1:0] cost;
    logic [NW-1:0]        pred;
  } node_ent_t;

  node_ent_t node_mem_q [NODES];
  node_ent_t nrd_q;
  logic      nwr_en;
  logic [NW-1:0] nwr_addr;
  node_ent_t nwr_data;
  logic [NW-1:0] nrd_addr;

  // path buffer, filled goal first and played back in reverse
  logic [NODE_FIELD_W-1:0] pbuf_q [MAX_PATH];
  logic                    pbuf_we;
  logic [PIW-1:0]          pbuf_wa;
  logic [NODE_FIELD_W-1:0] pbuf_wd;

  logic [2:0]           state_q, state_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic                 iss_q, iss_d;
  logic                 rsp_vld_q, rsp_vld_d;
  logic [NW-1:0]        rsp_idx_q, rsp_idx_d;
  logic                 best_vld_q, best_vld_d;
  logic [NW-1:0]        best_idx_q, best_idx_d;
  logic [DIST_BITS-1:0] best_dist_q, best_dist_d;
  logic [NW-1:0]        best_pred_q, best_pred_d;
  logic [NW-1:0]        start_q, start_d;
  logic [NW-1:0]        goal_q, goal_d;
  logic [NW-1:0]        cur_q, cur_d;
  logic [PLW-1:0]       plen_q, plen_d;
  logic [PIW-1:0]       ek_q, ek_d;
  logic                 ovalid_q, ovalid_d;
  logic                 ofound_q, ofound_d;

  // edge store
  logic                   clr_busy;
  logic                   ewr_en;
  logic [EAW-1:0]         ewr_addr;
  logic [EAW-1:0]         erd_addr;
  logic                   erd_present;
  logic [WEIGHT_BITS-1:0] erd_weight;

  logic          in_beat;
  logic          src_ok, dst_ok;
  logic [NW-1:0] src_idx, dst_idx;

  assign in_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign in_beat    = in_i.valid && in_i.ready;
  assign src_ok     = 32'(in_i.data.source_node) < NODES;
  assign dst_ok     = 32'(in_i.data.target_node) < NODES;
  assign src_idx    = NW'(in_i.data.source_node);
  assign dst_idx    = NW'(in_i.data.target_node);

  // edge writes go straight to the memory; out-of-range writes drop
  assign ewr_en   = in_beat && (in_i.data.opcode == OP_WRITE) && src_ok && dst_ok;
  assign ewr_addr = EAW'(32'(src_idx) * NODES + 32'(dst_idx));
  assign erd_addr = EAW'(32'(best_idx_q) * NODES + 32'(cnt_q));

  spd_edge_store #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_edge_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (ewr_en),
    .wr_addr_i    (ewr_addr),
    .wr_present_i (in_i.data.edge_present),
    .wr_weight_i  (WEIGHT_BITS'(in_i.data.edge_weight)),
    .rd_addr_i    (erd_addr),
    .rd_present_o (erd_present),
    .rd_weight_o  (erd_weight),
    .busy_o       (clr_busy)
  );

  // selection compare: strict less keeps the lowest index on ties
  logic cand;
  assign cand = rsp_vld_q && nrd_q.reached && !nrd_q.finished &&
                (!best_vld_q || (nrd_q.cost < best_dist_q));

  // relaxation with saturating distance
  logic [SW-1:0]        nd_sum;
  logic [DIST_BITS-1:0] nd;
  logic                 rlx_upd;
  assign nd_sum  = SW'(best_dist_q) + SW'(erd_weight);
  assign nd      = (nd_sum > DIST_MAX_W) ? DIST_MAX : DIST_BITS'(nd_sum);
  assign rlx_upd = rsp_vld_q && erd_present && (!nrd_q.reached || (nd < nrd_q.cost));

  logic rsp_last;
  assign rsp_last = rsp_vld_q && (rsp_idx_q == LAST_NODE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rsp_vld_d   = 1'b0;
    rsp_idx_d   = rsp_idx_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    best_pred_d = best_pred_q;
    start_d     = start_q;
    goal_d      = goal_q;
    cur_d       = cur_q;
    plen_d      = plen_q;
    ek_d        = ek_q;
    ovalid_d    = ovalid_q;
    ofound_d    = ofound_q;
    nwr_en      = 1'b0;
    nwr_addr    = cnt_q;
    nwr_data    = '0;
    nrd_addr    = cnt_q;
    pbuf_we     = 1'b0;
    pbuf_wa     = PIW'(plen_q);
    pbuf_wd     = NODE_FIELD_W'(goal_q);

    // sweep issue shared by select and relax
    if ((state_q == ST_SEL || state_q == ST_RLX) && iss_q) begin
      rsp_vld_d = 1'b1;
      rsp_idx_d = cnt_q;
      if (cnt_q == LAST_NODE) begin
        iss_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && (in_i.data.opcode == OP_FIND)) begin
          if (src_ok && dst_ok) begin
            start_d = src_idx;
            goal_d  = dst_idx;
            cnt_d   = '0;
            state_d = ST_INIT;
          end else begin
            ovalid_d = 1'b1;
            ofound_d = 1'b0;
            state_d  = ST_EMIT;
          end
        end
      end
      ST_INIT: begin
        nwr_en = 1'b1;
        if (cnt_q == start_q) begin
          nwr_data.reached = 1'b1;
          nwr_data.pred    = start_q;
        end
        if (cnt_q == LAST_NODE) begin
          cnt_d      = '0;
          iss_d      = 1'b1;
          best_vld_d = 1'b0;
          state_d    = ST_SEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SEL: begin
        if (cand) begin
          best_vld_d  = 1'b1;
          best_idx_d  = rsp_idx_q;
          best_dist_d = nrd_q.cost;
          best_pred_d = nrd_q.pred;
        end
        if (rsp_last) begin
          if (best_vld_q || cand) begin
            state_d = ST_FIN;
          end else begin
            ovalid_d = 1'b1;
            ofound_d = 1'b0;
            state_d  = ST_EMIT;
          end
        end
      end
      ST_FIN: begin
        nwr_en   = 1'b1;
        nwr_addr = best_idx_q;
        nwr_data = '{reached: 1'b1, finished: 1'b1, cost: best_dist_q, pred: best_pred_q};
        if (best_idx_q == goal_q) begin
          cur_d   = goal_q;
          plen_d  = PLW'(1);
          pbuf_we = 1'b1;
          pbuf_wa = '0;
          state_d = ST_WALK;
        end else begin
          cnt_d   = '0;
          iss_d   = 1'b1;
          state_d = ST_RLX;
        end
      end
      ST_RLX: begin
        if (rlx_upd) begin
          nwr_en   = 1'b1;
          nwr_addr = rsp_idx_q;
          nwr_data = '{reached: 1'b1, finished: nrd_q.finished, cost: nd, pred: best_idx_q};
        end
        if (rsp_last) begin
          cnt_d      = '0;
          iss_d      = 1'b1;
          best_vld_d = 1'b0;
          state_d    = ST_SEL;
        end
      end
      ST_WALK: begin
        if ((cur_q != start_q) && (plen_q < PLW'(MAX_PATH))) begin
          nrd_addr = cur_q;
          state_d  = ST_WALKW;
        end else begin
          ek_d     = PIW'(plen_q - 1'b1);
          ovalid_d = 1'b1;
          ofound_d = 1'b1;
          state_d  = ST_EMIT;
        end
      end
      ST_WALKW: begin
        cur_d   = nrd_q.pred;
        pbuf_we = 1'b1;
        pbuf_wd = NODE_FIELD_W'(nrd_q.pred);
        plen_d  = plen_q + 1'b1;
        state_d = ST_WALK;
      end
      ST_EMIT: begin
        if (out_o.ready) begin
          if (!ofound_q || (ek_q == '0)) begin
            ovalid_d = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            ek_d = ek_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= 1'b0;
      rsp_vld_q   <= 1'b0;
      rsp_idx_q   <= '0;
      best_vld_q  <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
      best_pred_q <= '0;
      start_q     <= '0;
      goal_q      <= '0;
      cur_q       <= '0;
      plen_q      <= '0;
      ek_q        <= '0;
      ovalid_q    <= 1'b0;
      ofound_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      rsp_vld_q   <= rsp_vld_d;
      rsp_idx_q   <= rsp_idx_d;
      best_vld_q  <= best_vld_d;
      best_idx_q  <= best_idx_d;
      best_dist_q <= best_dist_d;
      best_pred_q <= best_pred_d;
      start_q     <= start_d;
      goal_q      <= goal_d;
      cur_q       <= cur_d;
      plen_q      <= plen_d;
      ek_q        <= ek_d;
      ovalid_q    <= ovalid_d;
      ofound_q    <= ofound_d;
    end
  end

  // node memory, read data registered
  always_ff @(posedge clk_i) begin
    if (nwr_en) begin
      node_mem_q[nwr_addr] <= nwr_data;
    end
    nrd_q <= node_mem_q[nrd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pbuf_we) begin
      pbuf_q[pbuf_wa] <= pbuf_wd;
    end
  end

  // output beat: path played back from the start end of the buffer
  assign out_o.valid = ovalid_q;
  always_comb begin
    out_o.data.path_node = ofound_q ? pbuf_q[ek_q] : '0;
    out_o.data.found     = ofound_q;
    out_o.data.last      = !ofound_q || (ek_q == '0);
  end

`ifndef ASSERT_OFF
  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (state_q == ST_EMIT))
    else $error("path beat offered outside playback");

  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.found) |-> out_o.data.last)
    else $error("not-found beat without last");

  a_walk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((plen_q != '0) && (plen_q <= PLW'(MAX_PATH))))
    else $error("path length out of range");

  a_fin_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> best_vld_q)
    else $error("finishing without a selected node");

  a_ready_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !ovalid_q)
    else $error("taking a request while a path beat waits");
`endif

endmodule

@@ rtl/spd_edge_store.sv @@
// ----------------------------------------------------------------------------
// spd_edge_store
// edge weight memory with present bit, swept clear after reset
// ----------------------------------------------------------------------------
module spd_edge_store #(
  parameter int unsigned NODES       = spd_pkg::NODES_DEF,
  parameter int unsigned WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF,
  localparam int unsigned EAW        = $clog2(NODES * NODES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [EAW-1:0]         wr_addr_i,
  input  logic                   wr_present_i,
  input  logic [WEIGHT_BITS-1:0] wr_weight_i,
  input  logic [EAW-1:0]         rd_addr_i,
  output logic                   rd_present_o,
  output logic [WEIGHT_BITS-1:0] rd_weight_o,
  output logic                   busy_o
);
  import spd_pkg::*;

  localparam int unsigned DEPTH = NODES * NODES;
  localparam logic [EAW-1:0] LAST_ADDR = EAW'(DEPTH - 1);

  logic [WEIGHT_BITS:0] mem_q [DEPTH];
  logic [WEIGHT_BITS:0] rd_q;
  logic                 clr_q;
  logic [EAW-1:0]       clr_cnt_q;

  // clear sweep over every entry after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_present_i, wr_weight_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_present_o = rd_q[WEIGHT_BITS];
  assign rd_weight_o  = rd_q[WEIGHT_BITS-1:0];
  assign busy_o       = clr_q;

endmodule

@@ dv/spd_checker.sv @@
// ----------------------------------------------------------------------------
// spd_checker
// watches request and path beats, predicts each path and compares beat by beat
// ----------------------------------------------------------------------------
module spd_checker
  import spd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  in_beat_t    req_data_i,
  input  logic        path_valid_i,
  input  logic        path_ready_i,
  input  out_beat_t   path_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N = NODES_DEF;

  logic [WEIGHT_BITS_DEF-1:0] edge_w [N*N];
  logic                       edge_on [N*N];
  out_beat_t                  path_q [$];

  function automatic void push_beat(logic [3:0] node, logic fnd, logic lst);
    out_beat_t b;
    b.path_node = node;
    b.found     = fnd;
    b.last      = lst;
    path_q.push_back(b);
  endfunction

  // dijkstra with lowest index tie break, strict improvement only
  task automatic predict_path(input int s, input int g);
    logic [DIST_BITS-1:0] cost [N];
    int                   pred [N];
    bit                   seen [N];
    bit                   done [N];
    int                   u;
    int                   hops [$];
    int                   cur;
    bit                   hit;
    logic [DIST_BITS:0]   nd;
    hit = 0;
    foreach (seen[i]) begin
      seen[i] = 0;
      done[i] = 0;
      cost[i] = '0;
      pred[i] = 0;
    end
    seen[s] = 1;
    pred[s] = s;
    for (int it = 0; it < N && !hit; it++) begin
      u = N;
      for (int v = 0; v < N; v++) begin
        if (seen[v] && !done[v] && (u == N || cost[v] < cost[u])) u = v;
      end
      if (u == N) break;
      done[u] = 1;
      if (u == g) begin
        hit = 1;
      end else begin
        for (int v = 0; v < N; v++) begin
          if (edge_on[u*N+v]) begin
            nd = cost[u] + edge_w[u*N+v];
            if (nd > {DIST_BITS{1'b1}}) nd = {DIST_BITS{1'b1}};
            if (!seen[v] || nd < cost[v]) begin
              seen[v] = 1;
              cost[v] = nd[DIST_BITS-1:0];
              pred[v] = u;
            end
          end
        end
      end
    end
    if (!hit) begin
      push_beat('0, 1'b0, 1'b1);
    end else begin
      cur = g;
      hops.push_front(cur);
      while (cur != s && hops.size() < MAX_PATH) begin
        cur = pred[cur];
        hops.push_front(cur);
      end
      foreach (hops[k]) push_beat(4'(hops[k]), 1'b1, k == hops.size() - 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (edge_on[i]) edge_on[i] = 0;
      path_q.delete();
      errors_o <= 0;
    end else begin
      if (path_valid_i && path_ready_i) begin
        if (path_q.size() == 0) begin
          $display("%0t unexpected path beat: actual %p", $time, path_data_i);
          errors_o <= errors_o + 1;
        end else begin
          if (path_q[0] !== path_data_i) begin
            $display("%0t path beat mismatch: expected %p actual %p",
                     $time, path_q[0], path_data_i);
            errors_o <= errors_o + 1;
          end
          void'(path_q.pop_front());
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (req_data_i.opcode == OP_WRITE) begin
          edge_on[req_data_i.source_node*N + req_data_i.target_node] =
            req_data_i.edge_present;
          if (req_data_i.edge_present)
            edge_w[req_data_i.source_node*N + req_data_i.target_node] =
              req_data_i.edge_weight[WEIGHT_BITS_DEF-1:0];
        end else begin
          predict_path(req_data_i.source_node, req_data_i.target_node);
        end
      end
    end
  end

  assign pending_o = path_q.size();
endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives edge writes and path queries into the shortest path engine with
// random idling on both channels; the checker predicts and compares paths
// ----------------------------------------------------------------------------
module testbench;
  import spd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N         = NODES_DEF;
  localparam int unsigned MAX_CYCLE = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned errors;
  int unsigned cycle;
  bit          calm;  // no idling while set

  spd_in_if  req_if ();
  spd_out_if path_if ();

  shortest_path_dijkstra dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (path_if.source)
  );

  spd_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .path_valid_i(path_if.valid),
    .path_ready_i(path_if.ready),
    .path_data_i (path_if.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // generous cycle limit, covers the clearing sweep and slow queries
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  // path receiver stalls about 30 percent of the time outside calm stretches
  always @(posedge clk_i) begin
    path_if.ready <= calm || ($urandom_range(99) >= 30);
  end

  // send one beat, with a random gap before it, hold until accepted
  task automatic send_beat(input in_beat_t b);
    while (!calm && $urandom_range(99) < 30) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // drop valid after the last beat and wait until every path beat is out
  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic write_edge(input int s, input int t, input int w, input bit on);
    in_beat_t b;
    b.opcode       = OP_WRITE;
    b.source_node  = NODE_FIELD_W'(s);
    b.target_node  = NODE_FIELD_W'(t);
    b.edge_weight  = WEIGHT_FIELD_W'(w);
    b.edge_present = on;
    send_beat(b);
  endtask

  task automatic query(input int s, input int g);
    in_beat_t b;
    b.opcode       = OP_FIND;
    b.source_node  = NODE_FIELD_W'(s);
    b.target_node  = NODE_FIELD_W'(g);
    b.edge_weight  = WEIGHT_FIELD_W'($urandom);
    b.edge_present = 1'($urandom);
    send_beat(b);
  endtask

  initial begin
    int s;
    int a;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    calm          = 0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, start equals goal, extremes, ties, removal
    query(0, 15);
    query(7, 7);
    write_edge(0, 1, 16'hffff, 1);
    write_edge(1, 15, 16'hffff, 1);
    write_edge(0, 15, 0, 1);
    query(0, 15);
    write_edge(0, 15, 16'hffff, 1);
    query(0, 15);
    write_edge(0, 2, 1, 1);
    write_edge(2, 15, 16'hfffe, 1);
    query(0, 15);                 // equal cost: direct edge and path through 2
    write_edge(0, 15, 0, 0);
    query(0, 15);
    query(15, 0);                 // unreachable
    write_edge(15, 15, 5, 1);     // self loop
    query(15, 15);
    for (int i = 0; i < 15; i++) write_edge(i, i + 1, 0, 1);
    query(0, 15);                 // zero weight chain through every node
    query(3, 12);

    // sender holds off until every path beat is out
    drain();

    // random: small graphs with many queries, plus edge removal as noise
    for (int n = 0; n < 380; n++) begin
      calm = (n >= 150 && n < 210);
      a = $urandom_range(99);
      if (a < 50) begin
        s = $urandom_range(N - 1);
        case ($urandom_range(2))
          0: write_edge(s, $urandom_range(N - 1), $urandom_range(15), 1);
          1: write_edge(s, (s + 1) % N, $urandom, 1);
          default: write_edge(s, $urandom_range(N - 1), $urandom, 1'($urandom));
        endcase
      end else begin
        query($urandom_range(N - 1), $urandom_range(N - 1));
      end
    end
    calm = 0;

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
